@@ rtl/core/cdflex_pkg.sv @@
// Shared types and constants of the conditional directive fragment lexer.
// Depends on nothing; the front, queue, back, top level and checker refer to it by scoped names.
`default_nettype none

package cdflex_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [2:0]  KW_CAP    = 3'd7;
    localparam logic [7:0]  MAX_DEPTH = 8'd255;
    localparam logic [15:0] LEN_MAX   = 16'hFFFF;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_OPEN_BRACE,
        PH_OPEN_DOLLAR,
        PH_OPEN_KW,
        PH_OPEN_SKIP,
        PH_BODY,
        PH_BODY_BRACE,
        PH_BODY_KW,
        PH_BODY_SKIP,
        PH_TRAIL
    } cdflex_phase_t;

    typedef enum logic [1:0] {
        V_NONE = 2'd0,
        V_EXPR = 2'd1,
        V_STMT = 2'd2
    } cdflex_verdict_t;

    // A classified input byte as it travels from the front to the back.
    typedef struct packed {
        logic       start_req;
        logic       expr_allowed;
        logic       stmt_allowed;
        logic [7:0] lower;
        logic       is_letter;
        logic       is_ident;
        logic       is_nul;
        logic       is_lbrace;
        logic       is_rbrace;
        logic       is_dollar;
        logic       is_semi;
        logic       is_eol;
    } cdflex_item_t;

endpackage

`default_nettype wire

@@ rtl/core/cdflex_scan_if.sv @@
// Input channel of the lexer: one source byte and its scan context per item.
// Stands alone; used by the front and the top level.
`default_nettype none

interface cdflex_scan_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [7:0] char_code;
    logic       expr_allowed;
    logic       stmt_allowed;

    modport source (output valid, start_req, char_code, expr_allowed, stmt_allowed,
                    input ready);
    modport sink   (input valid, start_req, char_code, expr_allowed, stmt_allowed,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/cdflex_result_if.sv @@
// Output channel of the lexer: one verdict and token length per item.
// Stands alone; used by the back and the top level.
`default_nettype none

interface cdflex_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [15:0] token_length;

    modport source (output valid, verdict, token_length, input ready);
    modport sink   (input valid, verdict, token_length, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cdflex_front.sv @@
// Front of the lexer: accepts bytes and classifies them for the scanner.
// Depends on cdflex_pkg and cdflex_scan_if.
`default_nettype none

module cdflex_front (
    cdflex_scan_if.sink           scan,
    input  logic                  q_full,
    output logic                  q_push,
    output cdflex_pkg::cdflex_item_t q_item
);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    logic [7:0] c;
    logic       letter;
    logic       digit;

    assign c      = scan.char_code;
    assign letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    assign digit  = (c >= 8'h30 && c <= 8'h39);

    assign scan.ready = !q_full;
    assign q_push     = scan.valid && !q_full;

    always_comb
    begin
        q_item.start_req    = scan.start_req;
        q_item.expr_allowed = scan.expr_allowed;
        q_item.stmt_allowed = scan.stmt_allowed;
        q_item.lower        = c | 8'h20;
        q_item.is_letter    = letter;
        q_item.is_ident     = letter || digit || c == CH_UNDER || c == CH_DOT;
        q_item.is_nul       = (c == CH_NUL);
        q_item.is_lbrace    = (c == CH_LBRACE);
        q_item.is_rbrace    = (c == CH_RBRACE);
        q_item.is_dollar    = (c == CH_DOLLAR);
        q_item.is_semi      = (c == CH_SEMI);
        q_item.is_eol       = (c == CH_LF) || (c == CH_CR);
    end

endmodule

`default_nettype wire

@@ rtl/core/cdflex_queue.sv @@
// Short queue of classified bytes between the front and the back.
// Depends on cdflex_pkg.
`default_nettype none

module cdflex_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  cdflex_pkg::cdflex_item_t push_item,
    output logic                     full,
    input  logic                     pop,
    output logic                     pop_valid,
    output cdflex_pkg::cdflex_item_t pop_item
);

    localparam int unsigned AW = cdflex_pkg::QUEUE_AW;

    cdflex_pkg::cdflex_item_t mem_reg [cdflex_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    assign full      = (count_reg == (AW+1)'(cdflex_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/cdflex_back.sv @@
// Back of the lexer: the scan state machine and the result register.
// Depends on cdflex_pkg and cdflex_result_if.
`default_nettype none

module cdflex_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  cdflex_pkg::cdflex_item_t q_item,
    output logic                     q_pop,
    cdflex_result_if.source          result
);

    localparam logic [55:0] KW_IF     = 56'h00_0000_0000_6669;
    localparam logic [55:0] KW_IFDEF  = 56'h00_0066_6564_6669;
    localparam logic [55:0] KW_IFNDEF = 56'h00_6665_646E_6669;
    localparam logic [55:0] KW_ENDIF  = 56'h00_0066_6964_6E65;
    localparam logic [55:0] KW_IFEND  = 56'h00_0064_6E65_6669;

    cdflex_pkg::cdflex_phase_t phase_reg, phase_next;
    logic [55:0] kw_reg, kw_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [7:0]  depth_reg, depth_next;
    logic        lb_reg, lb_next;
    logic        semi_reg, semi_next;
    logic        eok_reg, eok_next;
    logic        sok_reg, sok_next;
    logic [15:0] len_reg, len_next;

    logic                        emit;
    cdflex_pkg::cdflex_verdict_t emit_verdict;

    logic                        out_valid_reg, out_valid_next;
    cdflex_pkg::cdflex_verdict_t verdict_reg, verdict_next;
    logic [15:0]                 out_len_reg, out_len_next;

    logic opener;
    logic closer;

    assign q_pop = q_valid && (!out_valid_reg || result.ready);

    // Next scan state for the byte at the head of the queue.
    always_comb
    begin : step
        logic take;
        logic do_oskip;
        logic do_body;
        logic do_bskip;

        phase_next   = phase_reg;
        kw_next      = kw_reg;
        cnt_next     = cnt_reg;
        depth_next   = depth_reg;
        lb_next      = lb_reg;
        semi_next    = semi_reg;
        eok_next     = eok_reg;
        sok_next     = sok_reg;
        take         = 1'b0;
        emit         = 1'b0;
        emit_verdict = cdflex_pkg::V_NONE;
        do_oskip     = 1'b0;
        do_body      = 1'b0;
        do_bskip     = 1'b0;
        opener       = 1'b0;
        closer       = 1'b0;

        if (q_item.start_req)
        begin
            phase_next = cdflex_pkg::PH_OPEN_BRACE;
            kw_next    = '0;
            cnt_next   = '0;
            depth_next = '0;
            lb_next    = 1'b0;
            semi_next  = 1'b0;
            eok_next   = q_item.expr_allowed;
            sok_next   = q_item.stmt_allowed;
        end

        opener = (cnt_next == 3'd2 && kw_next == KW_IF)
              || (cnt_next == 3'd5 && kw_next == KW_IFDEF)
              || (cnt_next == 3'd6 && kw_next == KW_IFNDEF);
        closer = (cnt_next == 3'd5 && (kw_next == KW_ENDIF || kw_next == KW_IFEND));

        case (phase_next)
            cdflex_pkg::PH_OPEN_BRACE:
            begin
                if ((!eok_next && !sok_next) || !q_item.is_lbrace)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    take       = 1'b1;
                    phase_next = cdflex_pkg::PH_OPEN_DOLLAR;
                end
            end
            cdflex_pkg::PH_OPEN_DOLLAR:
            begin
                if (!q_item.is_dollar)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    take       = 1'b1;
                    kw_next    = '0;
                    cnt_next   = '0;
                    phase_next = cdflex_pkg::PH_OPEN_KW;
                end
            end
            cdflex_pkg::PH_OPEN_KW:
            begin
                if (cnt_next < cdflex_pkg::KW_CAP && q_item.is_letter)
                begin
                    kw_next  = kw_next | ({48'b0, q_item.lower} << {cnt_next, 3'b000});
                    cnt_next = cnt_next + 3'd1;
                    take     = 1'b1;
                end
                else if (!opener)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    do_oskip = 1'b1;
                end
            end
            cdflex_pkg::PH_OPEN_SKIP:
            begin
                do_oskip = 1'b1;
            end
            cdflex_pkg::PH_BODY:
            begin
                do_body = 1'b1;
            end
            cdflex_pkg::PH_BODY_BRACE:
            begin
                if (q_item.is_dollar)
                begin
                    take       = 1'b1;
                    kw_next    = '0;
                    cnt_next   = '0;
                    phase_next = cdflex_pkg::PH_BODY_KW;
                end
                else
                begin
                    do_body = 1'b1;
                end
            end
            cdflex_pkg::PH_BODY_KW:
            begin
                if (cnt_next < cdflex_pkg::KW_CAP && q_item.is_letter)
                begin
                    kw_next  = kw_next | ({48'b0, q_item.lower} << {cnt_next, 3'b000});
                    cnt_next = cnt_next + 3'd1;
                    take     = 1'b1;
                end
                else if (opener && depth_next == cdflex_pkg::MAX_DEPTH)
                begin
                    emit = 1'b1;
                end
                else
                begin
                    if (opener)
                    begin
                        depth_next = depth_next + 8'd1;
                    end
                    else if (closer && depth_next != '0)
                    begin
                        depth_next = depth_next - 8'd1;
                    end
                    do_bskip = 1'b1;
                end
            end
            cdflex_pkg::PH_BODY_SKIP:
            begin
                do_bskip = 1'b1;
            end
            cdflex_pkg::PH_TRAIL:
            begin
                if (q_item.is_ident)
                begin
                    take = 1'b1;
                end
                else
                begin
                    emit         = 1'b1;
                    emit_verdict = cdflex_pkg::V_EXPR;
                end
            end
            default:
            begin
                phase_next = cdflex_pkg::PH_IDLE;
            end
        endcase

        if (do_oskip)
        begin
            if (q_item.is_nul)
            begin
                emit = 1'b1;
            end
            else
            begin
                take = 1'b1;
                if (q_item.is_rbrace)
                begin
                    depth_next = 8'd1;
                    phase_next = cdflex_pkg::PH_BODY;
                end
                else
                begin
                    phase_next = cdflex_pkg::PH_OPEN_SKIP;
                end
            end
        end

        if (do_body)
        begin
            if (q_item.is_nul)
            begin
                emit = 1'b1;
            end
            else
            begin
                take = 1'b1;
                if (q_item.is_lbrace)
                begin
                    phase_next = cdflex_pkg::PH_BODY_BRACE;
                end
                else
                begin
                    phase_next = cdflex_pkg::PH_BODY;
                    lb_next    = lb_next || q_item.is_eol;
                    semi_next  = semi_next || (q_item.is_semi && depth_next == 8'd1);
                end
            end
        end

        if (do_bskip)
        begin
            if (q_item.is_nul)
            begin
                emit = 1'b1;
            end
            else
            begin
                take       = 1'b1;
                phase_next = cdflex_pkg::PH_BODY_SKIP;
                if (q_item.is_rbrace)
                begin
                    if (depth_next != '0)
                    begin
                        phase_next = cdflex_pkg::PH_BODY;
                    end
                    else if (lb_next)
                    begin
                        emit = 1'b1;
                    end
                    else if (semi_next && sok_next)
                    begin
                        emit         = 1'b1;
                        emit_verdict = cdflex_pkg::V_STMT;
                    end
                    else if (!eok_next)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        phase_next = cdflex_pkg::PH_TRAIL;
                    end
                end
            end
        end

        len_next = q_item.start_req ? '0 : len_reg;
        if (take && len_next != cdflex_pkg::LEN_MAX)
        begin
            len_next = len_next + 16'd1;
        end

        if (emit)
        begin
            phase_next = cdflex_pkg::PH_IDLE;
        end
    end

    // Result register: loads on a deciding byte, drains when the sink takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        verdict_next   = verdict_reg;
        out_len_next   = out_len_reg;
        if (q_pop && emit)
        begin
            out_valid_next = 1'b1;
            verdict_next   = emit_verdict;
            out_len_next   = (emit_verdict == cdflex_pkg::V_NONE) ? '0 : len_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.verdict      = verdict_reg;
    assign result.token_length = out_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cdflex_pkg::PH_IDLE;
            cnt_reg       <= '0;
            depth_reg     <= '0;
            lb_reg        <= 1'b0;
            semi_reg      <= 1'b0;
            eok_reg       <= 1'b0;
            sok_reg       <= 1'b0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                depth_reg <= depth_next;
                lb_reg    <= lb_next;
                semi_reg  <= semi_next;
                eok_reg   <= eok_next;
                sok_reg   <= sok_next;
                len_reg   <= len_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            kw_reg <= kw_next;
        end
        verdict_reg <= verdict_next;
        out_len_reg <= out_len_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/conditional_directive_fragment_lexer_unit.sv @@
// Top level of the conditional directive fragment lexer.
// Depends on cdflex_pkg, the two channel interfaces, front, queue and back.
`default_nettype none

// The lexer takes one source byte per cycle on scan and gives at most one
// verdict per scan attempt on result: no token, an expression fragment or a
// statement fragment, with its length in bytes saturated at 65535. A byte
// reaches the scan state machine through a four-item queue, and the verdict
// it decides loads the result register in the cycle after the byte is taken.
// The state machine takes one byte per cycle whenever the result register is
// free or being drained, so throughput is one item per cycle; scan drops
// ready only when the queue is full because result is held off.

module conditional_directive_fragment_lexer_unit (
    input  logic            clk,
    input  logic            rst_n,
    cdflex_scan_if.sink     scan,
    cdflex_result_if.source result
);

    localparam logic [15:0] MIN_EXPR_LEN = 16'd13;
    localparam logic [15:0] MIN_STMT_LEN = 16'd14;

    logic                     q_full;
    logic                     q_push;
    cdflex_pkg::cdflex_item_t push_item;
    logic                     q_pop;
    logic                     q_valid;
    cdflex_pkg::cdflex_item_t pop_item;

    cdflex_front u_front (
        .scan   (scan),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (push_item)
    );

    cdflex_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (pop_item)
    );

    cdflex_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .result  (result)
    );

    a_none_has_no_length: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.verdict == cdflex_pkg::V_NONE |-> result.token_length == '0)
        else $error("rejection carries a nonzero length");

    a_stmt_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.verdict == cdflex_pkg::V_STMT
        |-> result.token_length >= MIN_STMT_LEN)
        else $error("statement fragment shorter than the smallest span");

    a_expr_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.verdict == cdflex_pkg::V_EXPR
        |-> result.token_length >= MIN_EXPR_LEN)
        else $error("expression fragment shorter than the smallest span");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid && (!result.valid || result.ready))
        else $error("scanner consumed an item it did not have");

endmodule

`default_nettype wire

@@ dv/cdflex_fragment_checker.sv @@
// Scoreboard of the conditional directive fragment lexer: watches both channels,
// predicts each verdict from the accepted source bytes and compares it with the result.
// Depends on cdflex_pkg and the cdflex_scan_if and cdflex_result_if interfaces.
`default_nettype none

module cdflex_fragment_checker (
    input  logic        clk,
    input  logic        rst_n,
    cdflex_scan_if      scan,
    cdflex_result_if    result,
    output int unsigned mismatch_count,
    output int unsigned awaiting
);

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        cdflex_pkg::cdflex_verdict_t verdict;
        logic [15:0]                 tok_len;
    } fragment_t;

    fragment_t     fragment_q[$];
    int unsigned   fails;

    cdflex_pkg::cdflex_phase_t scan_phase;
    logic [55:0]   kw_text;
    logic [2:0]    kw_len;
    logic [7:0]    depth;
    logic          line_break;
    logic          outer_semi;
    logic          expr_en;
    logic          stmt_en;
    logic [15:0]   tok_len;

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_chain(input logic [7:0] c);
        return is_alpha(c) || (c >= "0" && c <= "9") || c == CH_UNDER || c == CH_DOT;
    endfunction

    function automatic bit kw_match(input int n, input logic [55:0] word);
        return kw_len == n && kw_text == word;
    endfunction

    function automatic bit kw_opener();
        return kw_match(2, "if") || kw_match(5, "ifdef") || kw_match(6, "ifndef");
    endfunction

    function automatic bit kw_closer();
        return kw_match(5, "endif") || kw_match(5, "ifend");
    endfunction

    function automatic void kw_clear();
        kw_text = '0;
        kw_len  = '0;
    endfunction

    function automatic void count_byte();
        if (tok_len != cdflex_pkg::LEN_MAX)
            tok_len = tok_len + 16'd1;
    endfunction

    function automatic void clear_scan();
        scan_phase = cdflex_pkg::PH_IDLE;
        kw_clear();
        depth      = '0;
        line_break = 1'b0;
        outer_semi = 1'b0;
        expr_en    = 1'b0;
        stmt_en    = 1'b0;
        tok_len    = '0;
    endfunction

    // Advances the scan by one byte; returns 1 when the byte decides a verdict.
    function automatic bit lex_byte(input logic start, input logic [7:0] c, input logic ea,
                                    input logic sa, output fragment_t frag);
        bit fire;
        bit done;
        fire = 1'b0;
        done = 1'b0;
        frag.verdict = cdflex_pkg::V_NONE;
        frag.tok_len = '0;
        if (start)
        begin
            clear_scan();
            expr_en    = ea;
            stmt_en    = sa;
            scan_phase = cdflex_pkg::PH_OPEN_BRACE;
        end
        for (int g = 0; g < 4 && !done; g++)
        begin
            done = 1'b1;
            case (scan_phase)
                cdflex_pkg::PH_OPEN_BRACE:
                    if ((!expr_en && !stmt_en) || c != CH_LBRACE)
                        fire = 1'b1;
                    else
                    begin
                        count_byte();
                        scan_phase = cdflex_pkg::PH_OPEN_DOLLAR;
                    end
                cdflex_pkg::PH_OPEN_DOLLAR:
                    if (c != CH_DOLLAR)
                        fire = 1'b1;
                    else
                    begin
                        count_byte();
                        kw_clear();
                        scan_phase = cdflex_pkg::PH_OPEN_KW;
                    end
                cdflex_pkg::PH_OPEN_KW:
                    if (kw_len < cdflex_pkg::KW_CAP && is_alpha(c))
                    begin
                        kw_text = {kw_text[47:0], c | 8'h20};
                        kw_len  = kw_len + 3'd1;
                        count_byte();
                    end
                    else if (!kw_opener())
                        fire = 1'b1;
                    else
                    begin
                        scan_phase = cdflex_pkg::PH_OPEN_SKIP;
                        done = 1'b0;
                    end
                cdflex_pkg::PH_OPEN_SKIP:
                    if (c == CH_NUL)
                        fire = 1'b1;
                    else
                    begin
                        count_byte();
                        if (c == CH_RBRACE)
                        begin
                            depth      = 8'd1;
                            scan_phase = cdflex_pkg::PH_BODY;
                        end
                    end
                cdflex_pkg::PH_BODY:
                    if (c == CH_NUL)
                        fire = 1'b1;
                    else if (c == CH_LBRACE)
                    begin
                        count_byte();
                        scan_phase = cdflex_pkg::PH_BODY_BRACE;
                    end
                    else
                    begin
                        if (c == CH_LF || c == CH_CR)
                            line_break = 1'b1;
                        else if (c == CH_SEMI && depth == 8'd1)
                            outer_semi = 1'b1;
                        count_byte();
                    end
                cdflex_pkg::PH_BODY_BRACE:
                    if (c == CH_DOLLAR)
                    begin
                        count_byte();
                        kw_clear();
                        scan_phase = cdflex_pkg::PH_BODY_KW;
                    end
                    else
                    begin
                        scan_phase = cdflex_pkg::PH_BODY;
                        done = 1'b0;
                    end
                cdflex_pkg::PH_BODY_KW:
                    if (kw_len < cdflex_pkg::KW_CAP && is_alpha(c))
                    begin
                        kw_text = {kw_text[47:0], c | 8'h20};
                        kw_len  = kw_len + 3'd1;
                        count_byte();
                    end
                    else if (kw_opener() && depth >= cdflex_pkg::MAX_DEPTH)
                        fire = 1'b1;
                    else
                    begin
                        if (kw_opener())
                            depth = depth + 8'd1;
                        else if (kw_closer() && depth != 0)
                            depth = depth - 8'd1;
                        scan_phase = cdflex_pkg::PH_BODY_SKIP;
                        done = 1'b0;
                    end
                cdflex_pkg::PH_BODY_SKIP:
                    if (c == CH_NUL)
                        fire = 1'b1;
                    else
                    begin
                        count_byte();
                        if (c == CH_RBRACE)
                        begin
                            if (depth != 0)
                                scan_phase = cdflex_pkg::PH_BODY;
                            else if (line_break)
                                fire = 1'b1;
                            else if (outer_semi && stmt_en)
                            begin
                                fire = 1'b1;
                                frag.verdict = cdflex_pkg::V_STMT;
                                frag.tok_len = tok_len;
                            end
                            else if (!expr_en)
                                fire = 1'b1;
                            else
                                scan_phase = cdflex_pkg::PH_TRAIL;
                        end
                    end
                cdflex_pkg::PH_TRAIL:
                    if (is_chain(c))
                        count_byte();
                    else
                    begin
                        fire = 1'b1;
                        frag.verdict = cdflex_pkg::V_EXPR;
                        frag.tok_len = tok_len;
                    end
                default:
                    scan_phase = cdflex_pkg::PH_IDLE;
            endcase
        end
        if (fire)
            scan_phase = cdflex_pkg::PH_IDLE;
        return fire;
    endfunction

    always @(posedge clk)
    begin
        fragment_t want;
        fragment_t made;
        if (!rst_n)
            clear_scan();
        else
        begin
            if (result.valid && result.ready)
            begin
                if (fragment_q.size() == 0)
                begin
                    fails = fails + 1;
                    if (fails <= 10)
                        $display("%0t: unexpected result: verdict %0d length %0d", $realtime,
                                 result.verdict, result.token_length);
                end
                else
                begin
                    want = fragment_q.pop_front();
                    if (result.verdict !== want.verdict || result.token_length !== want.tok_len)
                    begin
                        fails = fails + 1;
                        if (fails <= 10)
                            $display({"%0t: mismatch: expected verdict %0d length %0d, ",
                                      "got verdict %0d length %0d"},
                                     $realtime, want.verdict, want.tok_len, result.verdict,
                                     result.token_length);
                    end
                end
            end
            if (scan.valid && scan.ready)
            begin
                if (lex_byte(scan.start_req, scan.char_code, scan.expr_allowed,
                             scan.stmt_allowed, made))
                    fragment_q.push_back(made);
            end
        end
        mismatch_count <= fails;
        awaiting       <= fragment_q.size();
    end

endmodule

`default_nettype wire

@@ dv/conditional_directive_fragment_lexer_unit_tb.sv @@
// Testbench top of the conditional directive fragment lexer: drives directed and random
// source text with bursty input and stalling output, and gives the verdict.
// Depends on cdflex_pkg, both channel interfaces, the block and cdflex_fragment_checker.
`default_nettype none

module conditional_directive_fragment_lexer_unit_tb;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_CR  = 8'h0D;

    logic        clk;
    logic        rst_n;
    int unsigned mismatch_count;
    int unsigned awaiting;
    int          burst_left;
    int          scanned_items;
    logic [7:0]  src_text[$];

    cdflex_scan_if   scan();
    cdflex_result_if result();

    conditional_directive_fragment_lexer_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan),
        .result (result)
    );

    cdflex_fragment_checker fragment_watch (
        .clk            (clk),
        .rst_n          (rst_n),
        .scan           (scan),
        .result         (result),
        .mismatch_count (mismatch_count),
        .awaiting       (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("** conditional_directive_fragment_lexer_unit: FAILED **");
        $finish;
    end

    initial
    begin
        logic [15:0] stall_mask;
        int          span;
        result.ready <= 1'b0;
        forever
        begin
            stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            span = $urandom_range(16, 96);
            for (int i = 0; i < span; i++)
            begin
                @(posedge clk);
                result.ready <= stall_mask[i % 16];
            end
        end
    end

    task automatic send_item(input logic start, input logic [7:0] c, input logic ea,
                             input logic sa);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                scan.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                     : $urandom_range(1, 16);
        end
        scan.valid        <= 1'b1;
        scan.start_req    <= start;
        scan.char_code    <= c;
        scan.expr_allowed <= ea;
        scan.stmt_allowed <= sa;
        @(posedge clk);
        while (!scan.ready)
            @(posedge clk);
        burst_left = burst_left - 1;
    endtask

    task automatic drain();
        scan.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
    endtask

    task automatic put(input string s);
        for (int i = 0; i < s.len(); i++)
            src_text.push_back(s[i]);
    endtask

    task automatic run_scan(input logic ea, input logic sa);
        foreach (src_text[i])
            send_item(i == 0, src_text[i], ea, sa);
        scanned_items = scanned_items + src_text.size();
        src_text.delete();
    endtask

    task automatic directed(input string s, input logic ea, input logic sa);
        put(s);
        run_scan(ea, sa);
    endtask

    function automatic string opener_word();
        case ($urandom_range(0, 5))
            0: return "if";
            1: return "ifdef";
            2: return "ifndef";
            3: return "IF";
            4: return "IfDef";
            default: return "ifNDef";
        endcase
    endfunction

    function automatic string closer_word();
        case ($urandom_range(0, 3))
            0: return "endif";
            1: return "ifend";
            2: return "ENDIF";
            default: return "IfEnd";
        endcase
    endfunction

    function automatic string filler_word();
        case ($urandom_range(0, 3))
            0: return "";
            1: return " X";
            2: return " defined(FOO)";
            default: return " ABC_1";
        endcase
    endfunction

    task automatic put_piece(input int level);
        int    r;
        string pool;
        pool = "abcdXYZ019 _.()+-=,";
        r = $urandom_range(0, 19);
        if (r < 9)
            src_text.push_back(pool[$urandom_range(0, pool.len() - 1)]);
        else if (r == 9)
            src_text.push_back(8'($urandom_range(32, 255)));
        else if (r < 12)
            put(";");
        else if (r == 12)
        begin
            if ($urandom_range(0, 2) == 0)
                put("\n");
            else
                put(" ");
        end
        else if (r == 13)
            put("{a}");
        else if (r == 14)
        begin
            if ($urandom_range(0, 1) == 0)
                put("{$else}");
            else
                put("{$define FOO}");
        end
        else if (r < 18 && level < 3)
            put_span(level + 1);
        else
            put("begin x := 1 end");
    endtask

    task automatic put_span(input int level);
        put("{$");
        put(opener_word());
        put(filler_word());
        put("}");
        repeat ($urandom_range(0, 4)) put_piece(level);
        put("{$");
        put(closer_word());
        put(filler_word());
        put("}");
    endtask

    task automatic put_trailer();
        string chain;
        chain = "aZ_.9";
        repeat ($urandom_range(0, 4))
            src_text.push_back(chain[$urandom_range(0, chain.len() - 1)]);
        case ($urandom_range(0, 5))
            0: put(" ");
            1: put(";");
            2: put("(");
            3: put("\n");
            4: src_text.push_back(CH_NUL);
            default: put("{");
        endcase
    endtask

    task automatic random_scan();
        logic ea;
        logic sa;
        int   cut;
        ea = ($urandom_range(0, 3) != 0);
        sa = ($urandom_range(0, 2) != 0);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 6)) src_text.push_back(8'($urandom));
        else
        begin
            put_span(0);
            put_trailer();
            if ($urandom_range(0, 7) == 0)
                src_text[$urandom_range(0, src_text.size() - 1)] = 8'($urandom);
            if ($urandom_range(0, 7) == 0)
            begin
                cut = $urandom_range(1, src_text.size() - 1);
                while (src_text.size() > cut)
                    void'(src_text.pop_back());
            end
        end
        run_scan(ea, sa);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom), ea, sa);
    endtask

    initial
    begin
        int    scans;
        scan.valid        <= 1'b0;
        scan.start_req    <= 1'b0;
        scan.char_code    <= '0;
        scan.expr_allowed <= 1'b0;
        scan.stmt_allowed <= 1'b0;
        rst_n             <= 1'b0;
        burst_left    = 0;
        scanned_items = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed("{$if}x{$endif} ", 1'b1, 1'b1);
        directed("{$IFDEF A};{$ENDIF}", 1'b0, 1'b1);
        directed("{$ifndef X}a;b{$ifend}foo.bar_9(", 1'b1, 1'b0);
        directed("{$if}", 1'b0, 1'b0);
        directed("{$if}a\nb{$endif} ", 1'b1, 1'b1);
        put("{$if}a");
        src_text.push_back(CH_CR);
        put("{$endif};");
        run_scan(1'b1, 1'b1);
        directed("x", 1'b1, 1'b1);
        directed("{x", 1'b1, 1'b1);
        directed("{$else}", 1'b1, 1'b1);
        directed("{$ifdefxy}", 1'b1, 1'b1);
        directed("{$endif}", 1'b1, 1'b1);
        directed("{$iF A}{$ifdef B};{$endif}{$EndIf}Z ", 1'b1, 1'b1);
        directed("{$if}{a}{$ifopt x}{$endif}", 1'b0, 1'b1);
        directed("{$if}{$ifdefined X}{$endif} ", 1'b1, 1'b1);
        put("{$if}ab");
        src_text.push_back(CH_NUL);
        run_scan(1'b1, 1'b1);
        put("{$if");
        src_text.push_back(CH_NUL);
        run_scan(1'b1, 1'b1);
        src_text.push_back(CH_NUL);
        run_scan(1'b1, 1'b1);
        directed("{$if}ab", 1'b1, 1'b1);
        directed("{$if};{$endif}x", 1'b1, 1'b1);
        send_item(1'b0, "z", 1'b1, 1'b1);
        send_item(1'b0, "z", 1'b0, 1'b0);
        put("{$if}");
        src_text.push_back(8'hFF);
        put("{$endif}");
        src_text.push_back(8'h80);
        run_scan(1'b1, 1'b1);
        drain();

        scans = 0;
        while (scanned_items < 650)
        begin
            random_scan();
            scans = scans + 1;
            if (scans == 6)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && awaiting == 0)
            $display("** conditional_directive_fragment_lexer_unit: PASSED **");
        else
            $display("** conditional_directive_fragment_lexer_unit: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
